FILE: sv/gls_pkg.sv
`timescale 1ns / 1ps

package gls_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LAP_W         = 20;
    localparam int CFG_W         = 7;
    localparam int CFG_MAX       = 127;
    localparam int EDGE_MIN      = 3;
    localparam int EDGE_RESET    = 64;
    localparam int GRID_EDGE_DEF = 64;
    localparam int DIMS_DEF      = 2;
    localparam int M_TDATA_W     = 24;
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

    // One stencil result as it leaves the block.
    typedef struct packed {
        logic signed [LAP_W-1:0] laplacian;
        logic                    at_border;
        logic                    last;
    } t_result;

    // Per-cell control: shift enable and plain-register mode.
    typedef struct packed {
        logic adv;
        logic bypass;
    } t_cell_ctl;

    // Integer power, used on constants at elaboration.
    function automatic int gls_pow(input int b, input int x);
        int r;
        r = 1;
        for (int i = 0; i < x; i++) begin
            r = r * b;
        end
        return r;
    endfunction

    // Exponent j of the cell's span e^j - e^(j-1); 0 marks a one-beat register cell.
    function automatic int gls_cell_span(input int m, input int dims);
        int j;
        if (m == 0) begin
            j = 0;
        end else if (m <= dims) begin
            j = dims - m;
        end else begin
            j = m - dims - 1;
        end
        return j;
    endfunction

    // Ring depth of a cell at the largest edge length.
    function automatic int gls_cell_depth(input int m, input int dims, input int emax);
        int j;
        int d;
        j = gls_cell_span(m, dims);
        if (j == 0) begin
            d = 2;
        end else begin
            d = gls_pow(emax, j) - gls_pow(emax, j - 1) - 1;
            if (d < 2) begin
                d = 2;
            end
        end
        return d;
    endfunction

    function automatic logic signed [LAP_W-1:0] gls_sext(input logic signed [SAMPLE_W-1:0] x);
        return {{(LAP_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
    endfunction

endpackage

FILE: sv/gls_cell.sv
`timescale 1ns / 1ps

// One delay cell of the sample chain. Each shift moves the input into a ring
// and the oldest ring entry into the output register, so the cell delays by
// i_last_ptr + 2 shifts. In bypass mode it is a single register.
module gls_cell #(
    parameter int DEPTH = 2,
    parameter int PTR_W = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gls_pkg::t_cell_ctl                   i_ctl,
    input  logic [PTR_W-1:0]                     i_last_ptr,
    input  logic signed [gls_pkg::SAMPLE_W-1:0]  i_data,
    output logic signed [gls_pkg::SAMPLE_W-1:0]  o_data
);
    import gls_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [0:DEPTH-1];
    logic signed [SAMPLE_W-1:0] r_data;
    logic [PTR_W-1:0]           r_ptr;
    logic [PTR_W-1:0]           n_ptr;

    assign n_ptr  = (r_ptr >= i_last_ptr) ? '0 : r_ptr + 1'b1;
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_ctl.adv && !i_ctl.bypass) begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_data <= i_ctl.bypass ? i_data : r_mem[r_ptr];
            if (!i_ctl.bypass) begin
                r_mem[r_ptr] <= i_data;
            end
        end
    end

endmodule

FILE: sv/gls_outq.sv
`timescale 1ns / 1ps

// Small result queue between the stencil and the output stream.
module gls_outq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  gls_pkg::t_result                   i_data,
    input  logic                               i_pop,
    output logic                               o_valid,
    output gls_pkg::t_result                   o_data,
    output logic [gls_pkg::OUTQ_CNT_W-1:0]     o_count
);
    import gls_pkg::*;

    localparam int AW = $clog2(OUTQ_DEPTH);

    t_result               r_mem [0:OUTQ_DEPTH-1];
    logic [AW-1:0]         r_wr;
    logic [AW-1:0]         r_rd;
    logic [OUTQ_CNT_W-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(OUTQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(OUTQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/grid_laplacian_stencil.sv
`timescale 1ns / 1ps

// Channel    Dir  Beat contents (lowest bit first)
// s_axis     in   tdata[15:0] sample (Q1.15); tuser drain
// m_axis     out  tdata[19:0] laplacian, [23:20] zero; tuser at_border; tlast last
// cfg        in   i_cfg_we, i_cfg_data edge_length (7 bits)
//
// One input beat per cycle is accepted while s_axis_tready is high; each beat yields at most one result.
// A result is registered in the window stage and then written to the output queue,
// and results trail the input by one grid line (plane for three
// dimensions, one sample for one dimension).
// After reset and after each edge_length write, s_axis_tready stays low
// while the edge powers settle; there is no clearing pass.
// A four-entry output queue keeps the input side running while results wait, until it fills.
module grid_laplacian_stencil #(
    parameter int GRID_EDGE = gls_pkg::GRID_EDGE_DEF,
    parameter int DIMS      = gls_pkg::DIMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gls_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gls_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [15:0] sample
    input  logic                              s_axis_tuser,   // [0] drain
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [gls_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // [19:0] laplacian, [23:20] zero
    output logic                              m_axis_tuser,   // [0] at_border
    output logic                              m_axis_tlast
);
    import gls_pkg::*;

    // Largest edge length the register can actually select.
    localparam int EMAX     = (GRID_EDGE < CFG_MAX) ? GRID_EDGE : CFG_MAX;
    localparam int E_W      = $clog2(EMAX + 1);
    localparam int POS_W    = $clog2(gls_pow(EMAX, DIMS) + 1);
    localparam int NCELL    = 2 * DIMS + 1;
    localparam int BUSY_W   = $clog2(DIMS + 1);
    localparam int EDGE_RST = (EDGE_RESET > EMAX) ? EMAX : EDGE_RESET;
    localparam logic [CFG_W-1:0] EMAX_CFG = CFG_W'(EMAX);
    localparam logic [CFG_W-1:0] EMIN_CFG = CFG_W'(EDGE_MIN);

    // ------------------------------------------------------------------
    // Configuration. r_pw[i] holds edge^i; the higher powers are formed one
    // multiply per cycle, and the busy count holds off input until they are
    // all in place.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  cfg_clamped;
    logic [POS_W-1:0]  r_pw [1:DIMS];
    logic [POS_W-1:0]  pw   [0:DIMS];
    logic [BUSY_W-1:0] r_busy;
    logic [E_W-1:0]    edge_len;
    logic [E_W-1:0]    edge_m1;

    always_comb begin
        priority if (i_cfg_data < EMIN_CFG) begin
            cfg_clamped = EMIN_CFG;
        end else if (i_cfg_data > EMAX_CFG) begin
            cfg_clamped = EMAX_CFG;
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw[1] <= POS_W'(EDGE_RST);
        end else if (i_cfg_we) begin
            r_pw[1] <= POS_W'(cfg_clamped);
        end
    end

    for (genvar i = 2; i <= DIMS; i++) begin : g_pow
        always_ff @(posedge i_clk) begin
            r_pw[i] <= POS_W'(r_pw[i-1] * r_pw[1][E_W-1:0]);
        end
    end

    always_comb begin
        pw[0] = POS_W'(1);
        for (int i = 1; i <= DIMS; i++) begin
            pw[i] = r_pw[i];
        end
    end

    assign edge_len = r_pw[1][E_W-1:0];
    assign edge_m1  = edge_len - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_busy <= BUSY_W'(DIMS - 1);
        end else if (r_busy != '0) begin
            r_busy <= r_busy - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Position tracking. The input position counts stored samples; the
    // output position and its coordinates follow the next result's point.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]      r_in_pos;
    logic [POS_W-1:0]      r_out_pos;
    logic [E_W-1:0]        r_coord [0:DIMS-1];
    logic [E_W-1:0]        n_coord [0:DIMS-1];
    logic [POS_W-1:0]      vol;
    logic [POS_W-1:0]      top;
    logic [POS_W-1:0]      in_new;
    logic [POS_W:0]        ahead_sum;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0]   occupancy;
    logic                  r_a_valid;
    logic                  r_a_border;
    logic                  r_a_last;
    logic                  in_acc;
    logic                  store;
    logic                  res;
    logic                  take;
    logic                  adv;
    logic                  border;
    logic                  at_end;

    assign vol = pw[DIMS];
    assign top = pw[DIMS-1];

    // Room is reserved for the result still in the window stage.
    assign occupancy     = (OUTQ_CNT_W + 1)'(q_count) + (OUTQ_CNT_W + 1)'(r_a_valid);
    assign s_axis_tready = (r_busy == '0) && (occupancy < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // A drain beat, or a sample past the end of the volume, stores nothing.
    assign store     = !s_axis_tuser && (r_in_pos < vol);
    assign in_new    = r_in_pos + POS_W'(store);
    assign ahead_sum = {1'b0, r_out_pos} + {1'b0, top};

    // A result is due once its point is one line behind the newest sample,
    // or once the whole volume has arrived.
    assign res  = (r_out_pos < in_new) && ((in_new == vol) || ({1'b0, in_new} > ahead_sum));
    assign take = in_acc && res;

    // The chain shifts on every stored sample and on every result; during the
    // tail of a volume it shifts in filler that no interior point reads.
    assign adv = in_acc && (store || res);

    always_comb begin
        logic carry;
        carry  = 1'b1;
        border = 1'b0;
        at_end = 1'b1;
        for (int d = 0; d < DIMS; d++) begin
            if ((r_coord[d] == '0) || (r_coord[d] == edge_m1)) begin
                border = 1'b1;
            end
            if (r_coord[d] != edge_m1) begin
                at_end = 1'b0;
            end
            if (carry) begin
                if (r_coord[d] == edge_m1) begin
                    n_coord[d] = '0;
                end else begin
                    n_coord[d] = r_coord[d] + 1'b1;
                    carry      = 1'b0;
                end
            end else begin
                n_coord[d] = r_coord[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_in_pos  <= '0;
            r_out_pos <= '0;
            for (int d = 0; d < DIMS; d++) begin
                r_coord[d] <= '0;
            end
        end else if (in_acc) begin
            if (take && at_end) begin
                // Final point of the volume: a new volume starts.
                r_in_pos  <= '0;
                r_out_pos <= '0;
                for (int d = 0; d < DIMS; d++) begin
                    r_coord[d] <= '0;
                end
            end else begin
                r_in_pos <= in_new;
                if (take) begin
                    r_out_pos <= r_out_pos + 1'b1;
                    for (int d = 0; d < DIMS; d++) begin
                        r_coord[d] <= n_coord[d];
                    end
                end
            end
        end
    end

    // Window stage: the result's point data is in the taps during the next
    // cycle, whatever the next beat does.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_border <= border;
            r_a_last   <= at_end;
        end
    end

    // ------------------------------------------------------------------
    // Chain of delay cells. Tap m lags the newest sample by the sum of the
    // cell delays up to m: taps DIMS-1-d and DIMS+1+d are the two neighbors
    // along dimension d and tap DIMS is the centre.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] tap [0:NCELL-1];

    for (genvar m = 0; m < NCELL; m++) begin : g_cell
        localparam int J     = gls_cell_span(m, DIMS);
        localparam int DEPTH = gls_cell_depth(m, DIMS, EMAX);
        localparam int PTR_W = $clog2(DEPTH);

        logic signed [SAMPLE_W-1:0] cell_in;
        logic [PTR_W-1:0]           last_ptr;
        t_cell_ctl                  ctl;

        if (m == 0) begin : g_head
            assign cell_in = s_axis_tdata;
        end else begin : g_link
            assign cell_in = tap[m-1];
        end

        if (J == 0) begin : g_reg
            assign last_ptr = '0;
        end else begin : g_ring
            // Cell delay is e^J - e^(J-1); the last ring index is two less.
            assign last_ptr = PTR_W'(pw[J] - pw[J-1] - POS_W'(2));
        end

        assign ctl = '{adv: adv, bypass: (J == 0)};

        gls_cell #(
            .DEPTH (DEPTH),
            .PTR_W (PTR_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_last_ptr (last_ptr),
            .i_data     (cell_in),
            .o_data     (tap[m])
        );
    end

    // ------------------------------------------------------------------
    // Stencil sum, exact at 20 bits. Border points pass the centre through.
    // ------------------------------------------------------------------
    logic signed [LAP_W-1:0] centre;
    logic signed [LAP_W-1:0] centre2;
    logic signed [LAP_W-1:0] acc;
    t_result                 res_data;
    t_result                 q_data;

    assign centre  = gls_sext(tap[DIMS]);
    assign centre2 = centre <<< 1;

    always_comb begin
        acc = '0;
        for (int d = 0; d < DIMS; d++) begin
            acc = acc + gls_sext(tap[DIMS-1-d]) + gls_sext(tap[DIMS+1+d]) - centre2;
        end
    end

    assign res_data = '{laplacian: (r_a_border ? centre : acc),
                        at_border: r_a_border,
                        last:      r_a_last};

    gls_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_a_valid),
        .i_data  (res_data),
        .i_pop   (m_axis_tvalid && m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign m_axis_tdata = {{(M_TDATA_W - LAP_W){1'b0}}, q_data.laplacian};
    assign m_axis_tuser = q_data.at_border;
    assign m_axis_tlast = q_data.last;

endmodule
